// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the drive mode RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== hw/rtl/dmhk_pkg.sv =====
// Types and constants for the drive mode selector.
package dmhk_pkg;

   // Operation codes of an input word
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_VEL    = 2'd1;
   localparam logic [1:0] OP_MANUAL = 2'd2;

   // Drive modes
   localparam logic [2:0] MODE_STOP  = 3'd0;
   localparam logic [2:0] MODE_FWD   = 3'd1;
   localparam logic [2:0] MODE_BACK  = 3'd2;
   localparam logic [2:0] MODE_LEFT  = 3'd3;
   localparam logic [2:0] MODE_RIGHT = 3'd4;

   // Register indexes
   localparam logic [2:0] CSR_START_LIN = 3'd0;
   localparam logic [2:0] CSR_STOP_LIN  = 3'd1;
   localparam logic [2:0] CSR_START_ANG = 3'd2;
   localparam logic [2:0] CSR_STOP_ANG  = 3'd3;
   localparam logic [2:0] CSR_PERIOD    = 3'd4;

   // Register reset values (0.06, 0.03, 0.10, 0.05 in Q4.12; 50 ms)
   localparam logic [14:0] RST_START_LIN = 15'd246;
   localparam logic [14:0] RST_STOP_LIN  = 15'd123;
   localparam logic [14:0] RST_START_ANG = 15'd410;
   localparam logic [14:0] RST_STOP_ANG  = 15'd205;
   localparam logic [15:0] RST_PERIOD    = 16'd50;

   localparam logic [15:0] TICK_MAX = 16'hFFFF;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] lin_vel;
      logic signed [15:0] ang_vel;
      logic [2:0]         manual_mode;
   } req_type;

   typedef struct packed {
      logic [2:0] drive_mode;
      logic       keep_alive;
   } rsp_type;

   typedef struct packed {
      logic [14:0] start_linear;
      logic [14:0] stop_linear;
      logic [14:0] start_angular;
      logic [14:0] stop_angular;
      logic [15:0] keepalive_period;
   } cfg_type;

   // What one word does to the state and the result register
   typedef struct packed {
      logic       emit;
      logic       keep_alive;
      logic       mode_we;
      logic [2:0] mode;
      logic       ticks_clr;
      logic       ticks_inc;
   } upd_type;

endpackage

// ===== hw/rtl/dmhk_csr.sv =====
// Configuration registers of the drive mode selector.
module dmhk_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output dmhk_pkg::cfg_type  cfg
);

   dmhk_pkg::cfg_type cfg_ff;
   dmhk_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dmhk_pkg::CSR_START_LIN: cfg_in.start_linear     = csr_wdata[14:0];
            dmhk_pkg::CSR_STOP_LIN:  cfg_in.stop_linear      = csr_wdata[14:0];
            dmhk_pkg::CSR_START_ANG: cfg_in.start_angular    = csr_wdata[14:0];
            dmhk_pkg::CSR_STOP_ANG:  cfg_in.stop_angular     = csr_wdata[14:0];
            dmhk_pkg::CSR_PERIOD:    cfg_in.keepalive_period = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_linear     <= dmhk_pkg::RST_START_LIN;
         cfg_ff.stop_linear      <= dmhk_pkg::RST_STOP_LIN;
         cfg_ff.start_angular    <= dmhk_pkg::RST_START_ANG;
         cfg_ff.stop_angular     <= dmhk_pkg::RST_STOP_ANG;
         cfg_ff.keepalive_period <= dmhk_pkg::RST_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/dmhk_decide.sv =====
// Mode decision: hysteresis, priority, keep-alive and manual override.
module dmhk_decide (
   input  dmhk_pkg::req_type  item,
   input  dmhk_pkg::cfg_type  cfg,
   input  logic [2:0]         mode,
   input  logic [15:0]        ticks,
   output dmhk_pkg::upd_type  upd
);

   logic [16:0] lin_mag;
   logic [16:0] ang_mag;
   logic [2:0]  lin_mode;
   logic [2:0]  ang_mode;
   logic        go_lin;
   logic        go_ang;
   logic        both_slow;
   logic [2:0]  cmd;
   logic [2:0]  man;

   // Exact magnitudes, 17 bits so that -32768 gives 32768
   always_comb begin
      lin_mag = item.lin_vel[15] ? (17'h10000 - {1'b0, item.lin_vel}) : {1'b0, item.lin_vel};
      ang_mag = item.ang_vel[15] ? (17'h10000 - {1'b0, item.ang_vel}) : {1'b0, item.ang_vel};
      lin_mode = (item.lin_vel > 16'sd0) ? dmhk_pkg::MODE_FWD  : dmhk_pkg::MODE_BACK;
      ang_mode = (item.ang_vel > 16'sd0) ? dmhk_pkg::MODE_LEFT : dmhk_pkg::MODE_RIGHT;
      go_lin   = lin_mag >= {2'b00, cfg.start_linear};
      go_ang   = ang_mag >= {2'b00, cfg.start_angular};
      both_slow = (lin_mag <= {2'b00, cfg.stop_linear}) &&
                  (ang_mag <= {2'b00, cfg.stop_angular});
   end

   // Next mode; the current mode picks which axis wins
   always_comb begin
      if (mode inside {dmhk_pkg::MODE_FWD, dmhk_pkg::MODE_BACK}) begin
         if (both_slow)   cmd = dmhk_pkg::MODE_STOP;
         else if (go_lin) cmd = lin_mode;
         else if (go_ang) cmd = ang_mode;
         else             cmd = mode;
      end else if (mode inside {dmhk_pkg::MODE_LEFT, dmhk_pkg::MODE_RIGHT}) begin
         if (both_slow)   cmd = dmhk_pkg::MODE_STOP;
         else if (go_ang) cmd = ang_mode;
         else if (go_lin) cmd = lin_mode;
         else             cmd = mode;
      end else begin
         if (go_lin)      cmd = lin_mode;
         else if (go_ang) cmd = ang_mode;
         else             cmd = dmhk_pkg::MODE_STOP;
      end
   end

   // Manual codes have left and right swapped
   always_comb begin
      case (item.manual_mode)
         dmhk_pkg::MODE_LEFT:  man = dmhk_pkg::MODE_RIGHT;
         dmhk_pkg::MODE_RIGHT: man = dmhk_pkg::MODE_LEFT;
         default:              man = item.manual_mode;
      endcase
   end

   // Effect of the word on state and result
   always_comb begin
      upd = '0;
      case (item.op)
         dmhk_pkg::OP_TICK: begin
            upd.ticks_inc = (ticks != dmhk_pkg::TICK_MAX);
         end
         dmhk_pkg::OP_VEL: begin
            upd.mode = cmd;
            if (cmd != mode) begin
               upd.emit      = 1'b1;
               upd.mode_we   = 1'b1;
               upd.ticks_clr = 1'b1;
            end else if (cmd != dmhk_pkg::MODE_STOP && ticks >= cfg.keepalive_period) begin
               upd.emit       = 1'b1;
               upd.keep_alive = 1'b1;
               upd.ticks_clr  = 1'b1;
            end
         end
         dmhk_pkg::OP_MANUAL: begin
            upd.mode = man;
            if (item.manual_mode <= dmhk_pkg::MODE_RIGHT) begin
               upd.emit      = 1'b1;
               upd.mode_we   = 1'b1;
               upd.ticks_clr = 1'b1;
            end
         end
         default: upd = '0;
      endcase
   end

endmodule

// ===== hw/rtl/drive_mode_hysteresis_keepalive.sv =====
// Drive mode selector top level: input register, state and result register.
//
// Input words arrive on req_ (valid/ready, payload req_data). Op 0 is a
// one-millisecond tick, op 1 a velocity command, op 2 a manual command.
// Each velocity or manual word gives zero or one result word on rsp_
// (valid/ready, payload rsp_data: drive_mode and keep_alive); ticks give none.
// Thresholds and the keep-alive period are written on csr_ (always ready);
// the user must write them only while the block is idle; the block does not enforce it.
// A word taken into the input register is decided combinationally; its result,
// if any, is loaded into the result register, which drives rsp_valid, once that
// register is empty or its result is being taken.
// Throughput: one word per cycle unless an untaken result stalls the input
// register; the decision, mode and tick counter all update as a word leaves it.
// Reset clears both registers, sets mode to stop, the tick count to zero and
// the thresholds to 0.06, 0.03, 0.10, 0.05 and the period to 50 ticks.
// When rsp_ready is low a result waits in the result register; one more
// word is still taken into the input register, after which req_ready drops
// until the result is taken.
`include "assert_macros.svh"

module drive_mode_hysteresis_keepalive (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dmhk_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dmhk_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   dmhk_pkg::cfg_type cfg;
   dmhk_pkg::upd_type upd;

   logic              in_valid_ff;
   logic              in_valid_in;
   dmhk_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   dmhk_pkg::rsp_type out_data_ff;
   logic [2:0]        mode_ff;
   logic [2:0]        mode_in;
   logic [15:0]       ticks_ff;
   logic [15:0]       ticks_in;
   logic              advance;
   logic              out_load;

   dmhk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dmhk_decide u_decide (
      .item  (in_data_ff),
      .cfg   (cfg),
      .mode  (mode_ff),
      .ticks (ticks_ff),
      .upd   (upd)
   );

   // Handshake and stage control
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign out_load  = advance && upd.emit;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      if (req_valid && req_ready)   in_valid_in = 1'b1;
      else if (advance)             in_valid_in = 1'b0;
      else                          in_valid_in = in_valid_ff;

      if (out_load)                 out_valid_in = 1'b1;
      else if (rsp_ready)           out_valid_in = 1'b0;
      else                          out_valid_in = out_valid_ff;
   end

   // State updates
   always_comb begin
      mode_in  = mode_ff;
      ticks_in = ticks_ff;
      if (advance) begin
         if (upd.mode_we)        mode_in  = upd.mode;
         if (upd.ticks_clr)      ticks_in = '0;
         else if (upd.ticks_inc) ticks_in = ticks_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= dmhk_pkg::MODE_STOP;
         ticks_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         ticks_ff     <= ticks_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (out_load) begin
         out_data_ff.drive_mode <= upd.mode;
         out_data_ff.keep_alive <= upd.keep_alive;
      end
   end

   `ASSERT_NEVER(a_mode_range, clock, reset, mode_ff > dmhk_pkg::MODE_RIGHT, "mode out of range")
   `ASSERT_NEVER(a_keep_not_stop, clock, reset, out_valid_ff && out_data_ff.keep_alive && (out_data_ff.drive_mode == dmhk_pkg::MODE_STOP), "keep-alive word with stop mode")
   `ASSERT_PROP(a_emit_clears_ticks, clock, reset, out_load |=> (ticks_ff == 16'd0), "tick count not cleared on result")
   `ASSERT_PROP(a_emit_matches_mode, clock, reset, out_load |=> (out_data_ff.drive_mode == mode_ff), "result word differs from mode")

endmodule
